FILE: src/gsd_pkg.sv
`default_nettype none
package gsd_pkg;

	localparam int FIELD_W = 36;
	localparam logic [7:0] BIAS = 8'd63;
	localparam logic [7:0] TOP_CHAR = 8'd126;
	localparam logic [5:0] SMALL_N = 6'd62;
	localparam logic [7:0] CH_COLON = 8'd58;
	localparam logic [7:0] CH_AMP = 8'd38;
	localparam logic [7:0] CH_SEMI = 8'd59;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_EDGE = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_ILLEGAL = 3'd1,
		ST_TRUNCATED = 3'd2,
		ST_TRAILING = 3'd3,
		ST_INCREMENTAL = 3'd4,
		ST_EMPTY = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		FM_NONE = 2'd0,
		FM_G6 = 2'd1,
		FM_D6 = 2'd2,
		FM_S6 = 2'd3
	} fmt_t;

	typedef enum logic [5:0] {
		PH_FIRST = 6'b000001,
		PH_SIZE0 = 6'b000010,
		PH_SIZE1 = 6'b000100,
		PH_SIZEREST = 6'b001000,
		PH_BODY = 6'b010000,
		PH_SKIP = 6'b100000
	} phase_t;

	typedef struct packed {
		kind_t kind;
		logic directed;
		logic [FIELD_W-1:0] vertex_count;
		logic [FIELD_W-1:0] edge_from;
		logic [FIELD_W-1:0] edge_to;
		status_t status;
	} res_t;

endpackage
`default_nettype wire

FILE: src/gsd_engine.sv
`default_nettype none
module gsd_engine #(
	parameter int VB = 36
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic go,
	input wire logic [7:0] char_code,
	input wire logic end_of_line,
	output logic emit,
	output logic done,
	output gsd_pkg::res_t res
);
	import gsd_pkg::*;

	localparam int IBW = $clog2(FIELD_W + 1);
	// The vertex count is kept modulo 2^VB; every other quantity runs at full width.
	localparam logic [FIELD_W-1:0] NMASK = {FIELD_W{1'b1}} >> (FIELD_W - VB);

	function automatic logic [IBW-1:0] bit_len(input logic [FIELD_W-1:0] t);
		logic [IBW-1:0] len;
		len = '0;
		for (int i = 0; i < FIELD_W; i++) begin
			if (t[i]) len = IBW'(i + 1);
		end
		return len;
	endfunction

	phase_t ph_q, ph_n;
	fmt_t fmt_q, fmt_n;
	status_t err_q, err_n;
	logic [FIELD_W-1:0] acc_q, acc_n, tot_q, tot_n, row_q, row_n, col_q, col_n;
	logic [FIELD_W-1:0] rv_q, rv_n;
	logic [FIELD_W:0] cv_q, cv_n;
	logic [2:0] left_q, left_n, bitpos_q, bitpos_n;
	logic [IBW-1:0] ib_q, ib_n, rbn_q, rbn_n;
	logic inc_q, inc_n, comp_q, comp_n, busy_q, busy_n;
	logic [5:0] buf_q, buf_n;

	logic [7:0] v8;
	logic [5:0] v;
	logic legal, do_bit, do_fin, bit_in;
	logic [5:0] word;
	logic [2:0] bit_idx;
	logic [FIELD_W-1:0] n_fin, r1, c1, rv_new, nm1;
	logic [IBW-1:0] len;
	logic [FIELD_W:0] cv_inc;

	always_comb begin
		v8 = char_code - BIAS;
		v = v8[5:0];
		legal = (char_code >= BIAS) && (char_code <= TOP_CHAR);
		ph_n = ph_q; fmt_n = fmt_q; err_n = err_q;
		acc_n = acc_q; tot_n = tot_q; row_n = row_q; col_n = col_q;
		rv_n = rv_q; cv_n = cv_q; left_n = left_q; bitpos_n = bitpos_q;
		ib_n = ib_q; rbn_n = rbn_q; inc_n = inc_q; comp_n = comp_q;
		busy_n = busy_q; buf_n = buf_q;
		emit = 1'b0; done = 1'b0; res = '0;
		do_bit = 1'b0; do_fin = 1'b0; n_fin = '0;
		word = busy_q ? buf_q : v;
		bit_idx = busy_q ? bitpos_q : 3'd0;
		bit_in = word[5];
		r1 = '0; c1 = '0; rv_new = '0; nm1 = '0; len = '0; cv_inc = '0;
		if (end_of_line) begin
			done = 1'b1;
			emit = 1'b1;
			res.kind = KIND_STATUS;
			if (err_q != ST_OK) res.status = err_q;
			else if (ph_q == PH_FIRST) res.status = ST_EMPTY;
			else if (ph_q != PH_BODY) res.status = ST_TRUNCATED;
			else if (fmt_q == FM_S6 || comp_q) res.status = ST_OK;
			else res.status = ST_TRUNCATED;
			ph_n = PH_FIRST; fmt_n = FM_NONE; err_n = ST_OK;
			acc_n = '0; tot_n = '0; row_n = '0; col_n = '0; rv_n = '0; cv_n = '0;
			left_n = '0; bitpos_n = '0; ib_n = IBW'(1); rbn_n = '0; inc_n = 1'b0;
			comp_n = 1'b0; busy_n = 1'b0; buf_n = '0;
		end else if (busy_q) begin
			do_bit = 1'b1;
		end else begin
			done = 1'b1;
			if (ph_q == PH_FIRST) begin
				if (char_code == CH_COLON) begin
					fmt_n = FM_S6; ph_n = PH_SIZE0;
				end else if (char_code == CH_AMP) begin
					fmt_n = FM_D6; ph_n = PH_SIZE0;
				end else if (char_code == CH_SEMI) begin
					err_n = ST_INCREMENTAL; ph_n = PH_SKIP;
				end else if (legal) begin
					fmt_n = FM_G6;
					if (v <= SMALL_N) begin
						do_fin = 1'b1; n_fin = FIELD_W'(v);
					end else begin
						ph_n = PH_SIZE1;
					end
				end else begin
					err_n = ST_ILLEGAL; ph_n = PH_SKIP;
				end
			end else if (!legal) begin
				err_n = ST_ILLEGAL; ph_n = PH_SKIP;
			end else begin
				case (ph_q)
					PH_SIZE0: begin
						if (v <= SMALL_N) begin
							do_fin = 1'b1; n_fin = FIELD_W'(v);
						end else begin
							ph_n = PH_SIZE1;
						end
					end
					PH_SIZE1: begin
						if (v <= SMALL_N) begin
							acc_n = FIELD_W'(v); left_n = 3'd2;
						end else begin
							acc_n = '0; left_n = 3'd6;
						end
						ph_n = PH_SIZEREST;
					end
					PH_SIZEREST: begin
						acc_n = {acc_q[FIELD_W-7:0], v};
						left_n = left_q - 3'd1;
						if (left_n == 3'd0) begin
							do_fin = 1'b1; n_fin = acc_n;
						end
					end
					PH_BODY: begin
						if (comp_q) begin
							if (fmt_q != FM_S6) begin
								err_n = ST_TRAILING; ph_n = PH_SKIP;
							end
						end else begin
							do_bit = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end

		if (do_fin) begin
			n_fin = n_fin & NMASK;
			tot_n = n_fin; row_n = '0; col_n = '0; ph_n = PH_BODY;
			if (fmt_n == FM_G6) begin
				col_n = FIELD_W'(1);
				comp_n = (n_fin <= FIELD_W'(1));
			end else begin
				comp_n = (n_fin == '0);
			end
			if (fmt_n == FM_S6) begin
				nm1 = (n_fin != '0) ? n_fin - FIELD_W'(1) : '0;
				len = bit_len(nm1);
				ib_n = (len == '0) ? IBW'(1) : len;
				cv_n = '0; rbn_n = '0; rv_n = '0; inc_n = 1'b0;
			end
			emit = 1'b1;
			res.kind = KIND_HEADER;
			res.directed = (fmt_n == FM_D6);
			res.vertex_count = n_fin;
		end

		if (do_bit) begin
			done = 1'b0;
			res.kind = KIND_EDGE;
			if (fmt_q == FM_G6) begin
				if (bit_in) begin
					emit = 1'b1;
					res.edge_from = row_q;
					res.edge_to = col_q;
				end
				r1 = row_q + FIELD_W'(1);
				if (r1 == col_q) begin
					row_n = '0; col_n = col_q + FIELD_W'(1);
				end else begin
					row_n = r1;
				end
				if (col_n >= tot_q) comp_n = 1'b1;
			end else if (fmt_q == FM_D6) begin
				if (bit_in) begin
					emit = 1'b1;
					res.edge_from = row_q;
					res.edge_to = col_q;
				end
				c1 = col_q + FIELD_W'(1);
				if (c1 >= tot_q) begin
					col_n = '0; row_n = row_q + FIELD_W'(1);
				end else begin
					col_n = c1;
				end
				if (row_n >= tot_q) comp_n = 1'b1;
			end else if (rbn_q == '0) begin
				inc_n = bit_in; rv_n = '0; rbn_n = ib_q;
			end else begin
				rv_new = {rv_q[FIELD_W-2:0], bit_in};
				rv_n = rv_new;
				rbn_n = rbn_q - IBW'(1);
				if (rbn_n == '0) begin
					cv_inc = (inc_q && !(&cv_q)) ? cv_q + (FIELD_W+1)'(1) : cv_q;
					if ({1'b0, rv_new} > cv_inc) begin
						cv_n = {1'b0, rv_new};
					end else begin
						cv_n = cv_inc;
						if (cv_inc < {1'b0, tot_q}) begin
							emit = 1'b1;
							res.edge_from = rv_new;
							res.edge_to = cv_inc[FIELD_W-1:0];
						end
					end
				end
			end
			done = (bit_idx == 3'd5) || comp_n;
			busy_n = !done;
			bitpos_n = bit_idx + 3'd1;
			buf_n = {word[4:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_FIRST; fmt_q <= FM_NONE; err_q <= ST_OK;
			acc_q <= '0; tot_q <= '0; row_q <= '0; col_q <= '0; rv_q <= '0; cv_q <= '0;
			left_q <= '0; bitpos_q <= '0; ib_q <= IBW'(1); rbn_q <= '0; inc_q <= 1'b0;
			comp_q <= 1'b0; busy_q <= 1'b0; buf_q <= '0;
		end else if (go) begin
			ph_q <= ph_n; fmt_q <= fmt_n; err_q <= err_n;
			acc_q <= acc_n; tot_q <= tot_n; row_q <= row_n; col_q <= col_n;
			rv_q <= rv_n; cv_q <= cv_n; left_q <= left_n; bitpos_q <= bitpos_n;
			ib_q <= ib_n; rbn_q <= rbn_n; inc_q <= inc_n; comp_q <= comp_n;
			busy_q <= busy_n; buf_q <= buf_n;
		end
	end

	a_busy_body: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (ph_q == PH_BODY) && !comp_q)
		else $error("bit walk outside an open body");
	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		(go && end_of_line) |=> (ph_q == PH_FIRST) && !busy_q)
		else $error("line end did not return to start");
	a_ib_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ib_q != '0)
		else $error("zero record width");

endmodule
`default_nettype wire

FILE: src/graph6_sparse6_decoder_top.sv
`default_nettype none
// Decodes one graph6, digraph6 or sparse6 line, one character per input transfer, into
// a header, the edges in stream order and one status at the line end. The vertex count
// is kept modulo 2^VERTEX_BITS. A body character is walked one bit per cycle by the
// decoder's bit step, up to its six bits; the result port takes one transfer per cycle,
// and a stalled port holds the walk.
// last_of_item is known because a result waits in a holding register before it goes
// to the output register, unless it is the final result of its item and that register
// is empty; the last result of an item may leave that register while the decoder
// already works on the next item.
module graph6_sparse6_decoder_top #(
	parameter int VERTEX_BITS = 36
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [7:0] char_code,
	input wire logic end_of_line,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] kind,
	output logic directed,
	output logic [35:0] vertex_count,
	output logic [35:0] edge_from,
	output logic [35:0] edge_to,
	output logic [2:0] status,
	output logic last_of_item
);
	import gsd_pkg::*;

	logic hold_q;
	logic [7:0] char_q;
	logic eol_q;
	res_t pend_q, out_q, r;
	logic pend_v_q, pend_fin_q, out_v_q, out_last_q;
	logic out_free, adv, emit, done;
	res_t pend_d, out_d;
	logic load_out, out_last_d, pend_v_d, pend_fin_d;

	assign out_free = !out_v_q || !out_stall;
	assign adv = hold_q && out_free;
	assign in_stall = hold_q && !(adv && done);

	gsd_engine #(.VB(VERTEX_BITS)) u_engine (
		.clk(clk), .arst_n(arst_n), .go(adv),
		.char_code(char_q), .end_of_line(eol_q),
		.emit(emit), .done(done), .res(r)
	);

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_q <= char_code;
			eol_q <= end_of_line;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= 1'b0;
		end else if (in_valid && !in_stall) begin
			hold_q <= 1'b1;
		end else if (adv && done) begin
			hold_q <= 1'b0;
		end
	end

	// A final result in the holding register moves out as soon as the output register is free,
	// in the same cycle in which the decoder may place the first result of the next item there.
	always_comb begin
		load_out = 1'b0;
		out_d = pend_q;
		out_last_d = 1'b0;
		pend_d = pend_q;
		pend_v_d = pend_v_q;
		pend_fin_d = pend_fin_q;
		if (pend_fin_q && out_free) begin
			load_out = 1'b1; out_d = pend_q; out_last_d = 1'b1;
			pend_v_d = 1'b0; pend_fin_d = 1'b0;
		end
		if (adv) begin
			if (emit) begin
				if (pend_fin_q) begin
					pend_d = r; pend_v_d = 1'b1; pend_fin_d = done;
				end else if (pend_v_q) begin
					load_out = 1'b1; out_d = pend_q; out_last_d = 1'b0;
					pend_d = r; pend_v_d = 1'b1; pend_fin_d = done;
				end else if (done) begin
					load_out = 1'b1; out_d = r; out_last_d = 1'b1;
				end else begin
					pend_d = r; pend_v_d = 1'b1;
				end
			end else if (done && pend_v_q && !pend_fin_q) begin
				load_out = 1'b1; out_d = pend_q; out_last_d = 1'b1;
				pend_v_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			pend_fin_q <= 1'b0;
			out_v_q <= 1'b0;
			out_last_q <= 1'b0;
			pend_q <= '0;
			out_q <= '0;
		end else begin
			out_v_q <= load_out || (out_v_q && out_stall);
			if (load_out) begin
				out_q <= out_d;
				out_last_q <= out_last_d;
			end
			pend_q <= pend_d;
			pend_v_q <= pend_v_d;
			pend_fin_q <= pend_fin_d;
		end
	end

	assign out_valid = out_v_q;
	assign kind = out_q.kind;
	assign directed = out_q.directed;
	assign vertex_count = out_q.vertex_count;
	assign edge_from = out_q.edge_from;
	assign edge_to = out_q.edge_to;
	assign status = out_q.status;
	assign last_of_item = out_last_q;

	a_fin_pend: assert property (@(posedge clk) disable iff (!arst_n)
		pend_fin_q |-> pend_v_q)
		else $error("final mark on empty holding register");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_stall) |-> !adv)
		else $error("decoder advanced while the result port was stalled");
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_stall) |=> out_v_q && $stable(out_q) && $stable(out_last_q))
		else $error("stalled result changed");
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.kind == KIND_STATUS) |-> out_last_q)
		else $error("status result not marked last");
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!hold_q |-> !in_stall)
		else $error("stall with empty input register");

endmodule
`default_nettype wire
